@@ rtl/window_stack_hit_test_and_drag_top_macros.svh @@
// Assertion macros for the window stack block.
// Used by window_stack_hit_test_and_drag_top; expects clk and rst in scope.
`ifndef WINDOW_STACK_HIT_TEST_AND_DRAG_TOP_MACROS_SVH
`define WINDOW_STACK_HIT_TEST_AND_DRAG_TOP_MACROS_SVH

// same-cycle implication
`define WSH_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define WSH_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/wsh_pkg.sv @@
// Shared types and constants for the window stack block.
// No dependencies; used by wsh_cell and the top level.
`timescale 1ns / 1ps

package wsh_pkg;

  // one window record
  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [12:0]        size_w;
    logic [12:0]        size_h;
    logic [3:0]         owner;
  } slot_t;

  // broadcast query to every cell
  typedef struct packed {
    logic [12:0] sx;
    logic [12:0] sy;
    logic [3:0]  client;
  } probe_t;

  // per-cell compare results
  typedef struct packed {
    logic hit;
    logic title;
    logic match;
  } cell_stat_t;

  typedef logic [1:0] cell_op_t;
  localparam cell_op_t CELL_HOLD = 2'd0;
  localparam cell_op_t CELL_TAKE = 2'd1;
  localparam cell_op_t CELL_LOAD = 2'd2;

  localparam logic [1:0] OP_CREATE  = 2'd0;
  localparam logic [1:0] OP_COMMIT  = 2'd1;
  localparam logic [1:0] OP_DESTROY = 2'd2;
  localparam logic [1:0] OP_MOUSE   = 2'd3;

  localparam logic [1:0] MSG_NONE  = 2'd0;
  localparam logic [1:0] MSG_CLICK = 2'd1;
  localparam logic [1:0] MSG_MOVE  = 2'd2;

  localparam logic CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic CFG_SCREEN_HEIGHT = 1'b1;

  localparam logic [13:0] SCREEN_W_RESET = 14'd1024;
  localparam logic [13:0] SCREEN_H_RESET = 14'd768;

  localparam logic [15:0] CASCADE_BASE = 16'd60;
  localparam logic [15:0] CASCADE_DX   = 16'd48;
  localparam logic [15:0] CASCADE_DY   = 16'd40;
  localparam logic [12:0] SIZE_MAX     = 13'd4096;

endpackage

@@ rtl/window_stack_hit_test_and_drag_top.sv @@
// Window stack with hit test and title-bar drag: top level.
// Depends on wsh_pkg, wsh_cell and window_stack_hit_test_and_drag_top_macros.svh.
//
// Usage:
// - Input channel (in_valid/in_ready) carries one item: op, client, size,
//   mouse motion and buttons. Output channel (out_valid/out_ready) returns
//   exactly one result item per input item, in order.
// - cfg_we/cfg_index/cfg_data write screen_width (0) or screen_height (1);
//   write only while the block is idle.
// - One item is worked on at a time. Create and commit go from accept
//   through the execute step straight to the result step. Destroy and mouse
//   events may first scan the stack; the scan walks the cell chain one slot
//   per cycle and covers at most MAX_WINDOWS slots.
// - Stack moves (destroy, raise) are a single step: every cell in the range takes
//   its upper neighbor's record at once.
// - The result sits in an output register; the next item is accepted while
//   it waits. A stalled receiver holds the block in its last step until the
//   register frees.
// - Reset empties the stack, centers the cursor for a 1024x768 screen and
//   ends any drag. Slot contents are not cleared.
`timescale 1ns / 1ps
`include "window_stack_hit_test_and_drag_top_macros.svh"

module window_stack_hit_test_and_drag_top #(
  parameter int MAX_WINDOWS  = 16,
  parameter int TITLE_HEIGHT = 22,
  localparam int IW = $clog2(MAX_WINDOWS),
  localparam int CW = $clog2(MAX_WINDOWS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic [3:0]         client,
  input  logic [12:0]        win_width,
  input  logic [12:0]        win_height,
  input  logic signed [9:0]  move_dx,
  input  logic signed [9:0]  move_dy,
  input  logic [2:0]         buttons,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               redraw,
  output logic               status,
  output logic [1:0]         msg_kind,
  output logic [3:0]         msg_client,
  output logic signed [15:0] msg_x,
  output logic signed [15:0] msg_y,
  output logic [2:0]         msg_buttons,
  output logic [12:0]        cursor_x,
  output logic [12:0]        cursor_y,
  output logic [CW-1:0]      window_total,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [13:0]        cfg_data
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_EXEC      = 4'd1;
  localparam logic [3:0] S_MOUSE     = 4'd2;
  localparam logic [3:0] S_HIT       = 4'd3;
  localparam logic [3:0] S_RAISE     = 4'd4;
  localparam logic [3:0] S_DRAG      = 4'd5;
  localparam logic [3:0] S_DEL_SCAN  = 4'd6;
  localparam logic [3:0] S_DEL_SHIFT = 4'd7;
  localparam logic [3:0] S_DONE      = 4'd8;

  localparam logic signed [17:0] TH = 18'(TITLE_HEIGHT);
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_WINDOWS);

  function automatic logic [12:0] clamp_axis(input logic [12:0] cur,
                                             input logic signed [9:0] d,
                                             input logic [13:0] scr);
    logic signed [15:0] lim;
    logic signed [15:0] n;
    lim = $signed({2'b0, scr}) - 16'sd2;
    if (lim < 16'sd0) lim = 16'sd0;
    if (lim > 16'sd8190) lim = 16'sd8190;
    n = $signed({3'b0, cur}) + {{6{d[9]}}, d};
    if (n < 16'sd0) n = 16'sd0;
    if (n > lim) n = lim;
    return n[12:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) r = 16'sh7fff;
    else if (v < -18'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  // control state
  logic [3:0]    state;
  logic [CW-1:0] count;
  logic [12:0]   cur_col, cur_row;
  logic          drag_active;
  logic [IW-1:0] drag_slot;
  logic [13:0]   scr_w, scr_h;
  logic [IW-1:0] idx;

  // latched item
  logic [1:0]        op_r;
  logic [3:0]        client_r;
  logic [12:0]       ww_r, wh_r;
  logic signed [9:0] dx_r, dy_r;
  logic [2:0]        btn_r;

  // working registers
  logic [12:0]         ncx, ncy;
  logic                hit_title;
  wsh_pkg::slot_t      tmp;
  logic                res_status, changed;
  logic [1:0]          res_kind;
  logic [3:0]          res_client;
  logic signed [15:0]  res_x, res_y;
  logic [2:0]          res_btn;

  // cell chain
  wsh_pkg::slot_t      cell_data [MAX_WINDOWS];
  wsh_pkg::cell_stat_t cell_stat [MAX_WINDOWS];
  wsh_pkg::cell_op_t   cell_op   [MAX_WINDOWS];
  wsh_pkg::probe_t     probe;
  wsh_pkg::slot_t      load_data;
  logic                load_en, take_en;
  logic [CW-1:0]       load_idx;

  wsh_pkg::slot_t      rd_slot;
  logic                create_ok;
  logic signed [17:0]  drag_nx, drag_ny, click_x, click_y;
  logic [CW-1:0]       idx_c, drag_slot_c;

  assign in_ready    = state == S_IDLE;
  assign rd_slot     = cell_data[idx];
  assign idx_c       = CW'(idx);
  assign drag_slot_c = CW'(drag_slot);
  assign probe.sx     = ncx;
  assign probe.sy     = ncy;
  assign probe.client = client_r;

  assign create_ok = (count < COUNT_MAX) && (ww_r != 13'd0) && (wh_r != 13'd0) &&
                     (ww_r <= wsh_pkg::SIZE_MAX) && (wh_r <= wsh_pkg::SIZE_MAX);

  always_comb begin
    drag_nx = {{2{rd_slot.pos_x[15]}}, rd_slot.pos_x} +
              ($signed({5'b0, ncx}) - $signed({5'b0, cur_col}));
    drag_ny = {{2{rd_slot.pos_y[15]}}, rd_slot.pos_y} +
              ($signed({5'b0, ncy}) - $signed({5'b0, cur_row}));
    click_x = $signed({5'b0, ncx}) - {{2{tmp.pos_x[15]}}, tmp.pos_x};
    click_y = $signed({5'b0, ncy}) - {{2{tmp.pos_y[15]}}, tmp.pos_y} - TH;
  end

  // what the cells do this cycle
  always_comb begin
    load_en   = 1'b0;
    take_en   = 1'b0;
    load_idx  = count;
    load_data = tmp;
    case (state)
      S_EXEC: begin
        load_en = (op_r == wsh_pkg::OP_CREATE) && create_ok;
        load_data.pos_x  = wsh_pkg::CASCADE_BASE + 16'(count) * wsh_pkg::CASCADE_DX;
        load_data.pos_y  = wsh_pkg::CASCADE_BASE + 16'(count) * wsh_pkg::CASCADE_DY;
        load_data.size_w = ww_r;
        load_data.size_h = wh_r;
        load_data.owner  = client_r;
      end
      S_RAISE: begin
        take_en  = 1'b1;
        load_en  = 1'b1;
        load_idx = count - CW'(1);
      end
      S_DEL_SHIFT: take_en = 1'b1;
      S_DRAG: begin
        load_en   = 1'b1;
        load_idx  = idx_c;
        load_data = rd_slot;
        load_data.pos_x = sat16(drag_nx);
        load_data.pos_y = sat16(drag_ny);
      end
      default: ;
    endcase
  end

  for (genvar j = 0; j < MAX_WINDOWS; j++) begin : g_cell
    localparam logic [CW:0] JX = (CW + 1)'(j);
    logic in_range;
    assign in_range = (JX >= {1'b0, idx_c}) && ((JX + 1'b1) < {1'b0, count});
    assign cell_op[j] = (load_en && JX == {1'b0, load_idx}) ? wsh_pkg::CELL_LOAD :
                        (take_en && in_range) ? wsh_pkg::CELL_TAKE : wsh_pkg::CELL_HOLD;
    if (j == MAX_WINDOWS - 1) begin : g_last
      wsh_cell #(.TITLE_HEIGHT(TITLE_HEIGHT)) u_cell (
        .clk(clk), .op(cell_op[j]), .load_data(load_data), .up_data(cell_data[j]),
        .probe(probe), .data(cell_data[j]), .stat(cell_stat[j]));
    end else begin : g_mid
      wsh_cell #(.TITLE_HEIGHT(TITLE_HEIGHT)) u_cell (
        .clk(clk), .op(cell_op[j]), .load_data(load_data), .up_data(cell_data[j+1]),
        .probe(probe), .data(cell_data[j]), .stat(cell_stat[j]));
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      scr_w <= wsh_pkg::SCREEN_W_RESET;
      scr_h <= wsh_pkg::SCREEN_H_RESET;
    end else if (cfg_we) begin
      if (cfg_index == wsh_pkg::CFG_SCREEN_WIDTH) scr_w <= cfg_data;
      else scr_h <= cfg_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      cur_col     <= 13'(wsh_pkg::SCREEN_W_RESET >> 1);
      cur_row     <= 13'(wsh_pkg::SCREEN_H_RESET >> 1);
      drag_active <= 1'b0;
      drag_slot   <= '0;
      out_valid   <= 1'b0;
      idx         <= '0;
    end else begin
      // S_DONE reloads the output register itself
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r       <= op;
            client_r   <= client;
            ww_r       <= win_width;
            wh_r       <= win_height;
            dx_r       <= move_dx;
            dy_r       <= move_dy;
            btn_r      <= buttons;
            res_status <= 1'b0;
            res_kind   <= wsh_pkg::MSG_NONE;
            res_client <= '0;
            res_x      <= '0;
            res_y      <= '0;
            res_btn    <= '0;
            changed    <= 1'b0;
            ncx        <= cur_col;
            ncy        <= cur_row;
            state      <= S_EXEC;
          end
        end
        S_EXEC: begin
          idx <= '0;
          case (op_r)
            wsh_pkg::OP_CREATE: begin
              if (create_ok) count <= count + CW'(1);
              else res_status <= 1'b1;
              state <= S_DONE;
            end
            wsh_pkg::OP_DESTROY: state <= (count == '0) ? S_DONE : S_DEL_SCAN;
            wsh_pkg::OP_MOUSE: begin
              ncx   <= clamp_axis(cur_col, dx_r, scr_w);
              ncy   <= clamp_axis(cur_row, dy_r, scr_h);
              state <= S_MOUSE;
            end
            default: state <= S_DONE;
          endcase
        end
        S_MOUSE: begin
          if (!btn_r[0]) begin
            drag_active <= 1'b0;
            state       <= S_DONE;
          end else if (!drag_active) begin
            idx   <= IW'(count - CW'(1));
            state <= (count == '0) ? S_DONE : S_HIT;
          end else if (drag_slot_c < count) begin
            idx   <= drag_slot;
            state <= S_DRAG;
          end else begin
            state <= S_DONE;
          end
        end
        S_HIT: begin
          // top-down scan, one slot per cycle
          if (cell_stat[idx].hit) begin
            hit_title <= cell_stat[idx].title;
            tmp       <= rd_slot;
            state     <= S_RAISE;
          end else if (idx == '0) begin
            state <= S_DONE;
          end else begin
            idx <= idx - IW'(1);
          end
        end
        S_RAISE: begin
          changed <= 1'b1;
          if (hit_title) begin
            drag_active <= 1'b1;
            drag_slot   <= IW'(count - CW'(1));
          end else begin
            res_kind   <= wsh_pkg::MSG_CLICK;
            res_client <= tmp.owner;
            res_x      <= sat16(click_x);
            res_y      <= sat16(click_y);
            res_btn    <= btn_r;
          end
          state <= S_DONE;
        end
        S_DRAG: begin
          changed    <= 1'b1;
          res_kind   <= wsh_pkg::MSG_MOVE;
          res_client <= rd_slot.owner;
          res_x      <= sat16(drag_nx);
          res_y      <= sat16(drag_ny);
          state      <= S_DONE;
        end
        S_DEL_SCAN: begin
          // bottom-up search for the client's first window
          if (cell_stat[idx].match) state <= S_DEL_SHIFT;
          else if (idx_c + CW'(1) >= count) state <= S_DONE;
          else idx <= idx + IW'(1);
        end
        S_DEL_SHIFT: begin
          count <= count - CW'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            redraw       <= (op_r != wsh_pkg::OP_MOUSE) || changed ||
                            (ncx != cur_col) || (ncy != cur_row);
            status       <= res_status;
            msg_kind     <= res_kind;
            msg_client   <= res_client;
            msg_x        <= res_x;
            msg_y        <= res_y;
            msg_buttons  <= res_btn;
            cursor_x     <= ncx;
            cursor_y     <= ncy;
            window_total <= count;
            cur_col      <= ncx;
            cur_row      <= ncy;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `WSH_ASSERT_NEXT(a_count_step, !rst, (count == $past(count)) || (count == $past(count) + CW'(1)) || (count == $past(count) - CW'(1)), "window count jumped")
  `WSH_ASSERT_NOW(a_click_left, out_valid && msg_kind == wsh_pkg::MSG_CLICK, msg_buttons[0] && redraw, "click without left button or redraw")
  `WSH_ASSERT_NOW(a_move_has_window, out_valid && msg_kind == wsh_pkg::MSG_MOVE, (window_total != '0) && redraw && (msg_buttons == 3'd0), "move result without window")

endmodule

@@ rtl/wsh_cell.sv @@
// One stack slot: holds a window record, shifts from its upper neighbor,
// and compares itself against the broadcast probe. Depends on wsh_pkg.
`timescale 1ns / 1ps

module wsh_cell #(
  parameter int TITLE_HEIGHT = 22
) (
  input  logic                clk,
  input  wsh_pkg::cell_op_t   op,
  input  wsh_pkg::slot_t      load_data,
  input  wsh_pkg::slot_t      up_data,
  input  wsh_pkg::probe_t     probe,
  output wsh_pkg::slot_t      data,
  output wsh_pkg::cell_stat_t stat
);

  localparam logic signed [17:0] TH = 18'(TITLE_HEIGHT);

  logic signed [17:0] sx, sy, px, py, x_end, y_title, y_end;

  always_ff @(posedge clk) begin
    case (op)
      wsh_pkg::CELL_TAKE: data <= up_data;
      wsh_pkg::CELL_LOAD: data <= load_data;
      default:            data <= data;
    endcase
  end

  always_comb begin
    sx      = $signed({5'b0, probe.sx});
    sy      = $signed({5'b0, probe.sy});
    px      = {{2{data.pos_x[15]}}, data.pos_x};
    py      = {{2{data.pos_y[15]}}, data.pos_y};
    x_end   = px + $signed({5'b0, data.size_w});
    y_title = py + TH;
    y_end   = y_title + $signed({5'b0, data.size_h});
    stat.hit   = (sx >= px) && (sx < x_end) && (sy >= py) && (sy < y_end);
    stat.title = sy < y_title;
    stat.match = data.owner == probe.client;
  end

endmodule
